[sv/tac_pkg.sv]
// shared types, codes and constants of the temperature alarm controller
package tac_pkg;

  localparam logic [7:0]  DEFAULT_LOW       = 8'd20;
  localparam logic [7:0]  DEFAULT_HIGH      = 8'd30;
  localparam logic [15:0] RST_PAUSE_TICKS   = 16'd800;
  localparam logic [15:0] RST_ON_TICKS      = 16'd150;
  localparam logic [7:0]  RST_LIMIT_CEILING = 8'd50;
  localparam logic [7:0]  RST_REARM_MARGIN  = 8'd5;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SAMPLE  = 3'd1,
    OP_RELEASE = 3'd2,
    OP_KEY1    = 3'd3,
    OP_KEY2    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_ALARM    = 2'd1,
    MODE_SET_LOW  = 2'd2,
    MODE_SET_HIGH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PAUSE = 2'd1,
    PH_SOUND = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_PAUSE_TICKS   = 2'd0,
    REG_ON_TICKS      = 2'd1,
    REG_LIMIT_CEILING = 2'd2,
    REG_REARM_MARGIN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] pause_ticks;
    logic [15:0] on_ticks;
    logic [7:0]  limit_ceiling;
    logic [7:0]  rearm_margin;
  } cfg_t;

  // packed from lsb: mode, buzzer_enable, buzzer_drive, pump_drive,
  // shown_value, save_low, save_high
  typedef struct packed {
    logic       save_high;
    logic       save_low;
    logic [7:0] shown_value;
    logic       pump_drive;
    logic       buzzer_drive;
    logic       buzzer_enable;
    logic [1:0] mode;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // handshake between the input register and the result register
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

  // x*10 as (x<<3)+(x<<1)
  function automatic logic [12:0] times_ten(input logic [8:0] x);
    logic [12:0] w;
    w = {4'd0, x};
    return (w << 3) + (w << 1);
  endfunction

endpackage

[sv/tac_in_stage.sv]
// input register: holds one accepted transaction until the result stage takes it
module tac_in_stage
  import tac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_temp,
  input  logic        take,
  output logic        s1_valid,
  output logic [2:0]  s1_op,
  output logic [15:0] s1_temp
);

  logic        v_r, v_nxt;
  logic [2:0]  op_r;
  logic [15:0] temp_r;

  assign in_tready = !v_r || take;
  assign v_nxt     = (in_tvalid && in_tready) ? 1'b1 : (take ? 1'b0 : v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_op;
      temp_r <= in_temp;
    end
  end

  assign s1_valid = v_r;
  assign s1_op    = op_r;
  assign s1_temp  = temp_r;

endmodule

[sv/tac_ctrl.sv]
// controller state and single-pass update for one transaction
module tac_ctrl
  import tac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [2:0]  op,
  input  logic [15:0] temp,
  input  cfg_t        cfg,
  output res_t        res
);

  mode_t       mode_r, mode_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [7:0]  high_r, high_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        pump_r, pump_nxt;
  logic [7:0]  disp_r, disp_nxt;
  logic        save_low, save_high;

  logic signed [16:0] temp_s, hi10, lo10, re10;
  logic [8:0]  high_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      phase_r <= PH_IDLE;
      low_r   <= DEFAULT_LOW;
      high_r  <= DEFAULT_HIGH;
      armed_r <= 1'b0;
      cnt_r   <= 16'd0;
      pump_r  <= 1'b1;
      disp_r  <= 8'd0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      armed_r <= armed_nxt;
      cnt_r   <= cnt_nxt;
      pump_r  <= pump_nxt;
      disp_r  <= disp_nxt;
    end
  end

  assign temp_s   = {temp[15], temp};
  assign hi10     = $signed({4'd0, times_ten({1'b0, high_r})});
  assign lo10     = $signed({4'd0, times_ten({1'b0, low_r})});
  assign re10     = $signed({4'd0, times_ten({1'b0, high_r} + {1'b0, cfg.rearm_margin})});
  assign high_inc = {1'b0, high_r} + 9'd1;

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    pump_nxt  = pump_r;
    disp_nxt  = disp_r;
    save_low  = 1'b0;
    save_high = 1'b0;
    case (op)
      OP_TICK: begin
        if (!armed_r) begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = 16'd0;
        end else begin
          case (phase_r)
            PH_PAUSE: begin
              if (cnt_r <= 16'd1) begin
                phase_nxt = PH_SOUND;
                cnt_nxt   = cfg.on_ticks;
              end else begin
                cnt_nxt = cnt_r - 16'd1;
              end
            end
            PH_SOUND: begin
              if (cnt_r <= 16'd1) begin
                phase_nxt = PH_IDLE;
                cnt_nxt   = 16'd0;
              end else begin
                cnt_nxt = cnt_r - 16'd1;
              end
            end
            default: begin
              phase_nxt = PH_PAUSE;
              cnt_nxt   = cfg.pause_ticks;
            end
          endcase
        end
      end
      OP_SAMPLE: begin
        if (mode_r == MODE_NORMAL) begin
          if (temp_s >= hi10) begin
            armed_nxt = 1'b1;
            mode_nxt  = MODE_ALARM;
          end
        end else if (mode_r == MODE_ALARM) begin
          if (temp_s <= lo10) begin
            armed_nxt = 1'b0;
            phase_nxt = PH_IDLE;
            cnt_nxt   = 16'd0;
            mode_nxt  = MODE_NORMAL;
          end
          if (temp_s >= re10) begin
            armed_nxt = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (mode_r == MODE_NORMAL || mode_r == MODE_ALARM) begin
          mode_nxt = MODE_SET_LOW;
          disp_nxt = low_r;
        end else if (mode_r == MODE_SET_LOW) begin
          mode_nxt = MODE_SET_HIGH;
          disp_nxt = high_r;
        end else begin
          mode_nxt = MODE_NORMAL;
        end
      end
      OP_KEY1, OP_KEY2: begin
        if (mode_r == MODE_NORMAL || mode_r == MODE_ALARM) begin
          // a press silences an armed buzzer, else toggles the pump
          if (armed_r) begin
            armed_nxt = 1'b0;
            phase_nxt = PH_IDLE;
            cnt_nxt   = 16'd0;
          end else begin
            pump_nxt = ~pump_r;
          end
        end else if (mode_r == MODE_SET_LOW) begin
          if (op == OP_KEY2) begin
            low_nxt = (low_r != 8'hFF) ? low_r + 8'd1 : 8'hFF;
            if (low_nxt == high_r) begin
              low_nxt = (high_r != 8'd0) ? high_r - 8'd1 : 8'd0;
            end
          end else begin
            low_nxt = (low_r != 8'd0) ? low_r - 8'd1 : 8'd0;
            if (low_nxt == 8'd0) begin
              low_nxt = 8'd1;
            end
          end
          disp_nxt = low_nxt;
          save_low = 1'b1;
        end else begin
          if (op == OP_KEY2) begin
            high_nxt = (high_inc > {1'b0, cfg.limit_ceiling}) ? cfg.limit_ceiling
                                                              : high_inc[7:0];
          end else begin
            high_nxt = (high_r != 8'd0) ? high_r - 8'd1 : 8'd0;
            if (high_nxt == low_r) begin
              high_nxt = (low_r != 8'hFF) ? low_r + 8'd1 : 8'hFF;
            end
          end
          disp_nxt  = high_nxt;
          save_high = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.mode          = mode_nxt;
    res.buzzer_enable = armed_nxt;
    res.buzzer_drive  = (phase_nxt == PH_SOUND);
    res.pump_drive    = pump_nxt;
    res.shown_value   = disp_nxt;
    res.save_low      = save_low;
    res.save_high     = save_high;
  end

endmodule

[sv/tac_out_stage.sv]
// result register: holds one finished result until the output side takes it
module tac_out_stage
  import tac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stage_ctl_t  ctl_in,
  output logic        can_take,
  input  res_t        res,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  logic v_r, v_nxt;
  res_t data_r;

  assign can_take = !v_r || out_tready;
  assign v_nxt    = ctl_in.take ? 1'b1 : ((v_r && out_tready) ? 1'b0 : v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.valid && ctl_in.take) begin
      data_r <= res;
    end
  end

  assign out_tvalid = v_r;
  assign out_tdata  = {{(16 - RES_W){1'b0}}, data_r};

endmodule

[sv/temperature_alarm_controller_core.sv]
// top level of the temperature alarm controller: apb registers and the two-stage datapath
// One transaction is accepted per clock when the output side keeps up: a transaction
// sits in the input register, its state update and result are formed there in a single
// pass, and the result is loaded into the output register when that register is free
// or being emptied, which raises out_tvalid until the result is taken. A stalled output
// holds the result register while the input register still takes one more transaction.
// Registers (byte address 4*i): 0 beep pause ticks, 1 beep on ticks, 2 limit ceiling,
// 3 rearm margin; write them only while no transaction is in flight.
module temperature_alarm_controller_core
  import tac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] temperature
  input  logic [2:0]  in_tuser,   // [2:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] mode, [2] buzzer_enable, [3] buzzer_drive,
                                  // [4] pump_drive, [12:5] shown_value, [13] save_low,
                                  // [14] save_high
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t        cfg_r;
  reg_idx_t    reg_idx;
  logic        cfg_wr;
  logic        s1_valid;
  logic [2:0]  s1_op;
  logic [15:0] s1_temp;
  logic        can_take;
  stage_ctl_t  ctl;
  res_t        res;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pause_ticks   <= RST_PAUSE_TICKS;
      cfg_r.on_ticks      <= RST_ON_TICKS;
      cfg_r.limit_ceiling <= RST_LIMIT_CEILING;
      cfg_r.rearm_margin  <= RST_REARM_MARGIN;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PAUSE_TICKS:   cfg_r.pause_ticks   <= cfg_pwdata[15:0];
        REG_ON_TICKS:      cfg_r.on_ticks      <= cfg_pwdata[15:0];
        REG_LIMIT_CEILING: cfg_r.limit_ceiling <= cfg_pwdata[7:0];
        REG_REARM_MARGIN:  cfg_r.rearm_margin  <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAUSE_TICKS:   cfg_prdata = {16'd0, cfg_r.pause_ticks};
      REG_ON_TICKS:      cfg_prdata = {16'd0, cfg_r.on_ticks};
      REG_LIMIT_CEILING: cfg_prdata = {24'd0, cfg_r.limit_ceiling};
      REG_REARM_MARGIN:  cfg_prdata = {24'd0, cfg_r.rearm_margin};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  assign ctl.valid = s1_valid;
  assign ctl.take  = s1_valid && can_take;

  tac_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_temp   (in_tdata),
    .take      (ctl.take),
    .s1_valid  (s1_valid),
    .s1_op     (s1_op),
    .s1_temp   (s1_temp)
  );

  tac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (ctl.take),
    .op    (s1_op),
    .temp  (s1_temp),
    .cfg   (cfg_r),
    .res   (res)
  );

  tac_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (ctl),
    .can_take   (can_take),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[sv/tac_checker.sv]
// port-level checks of the temperature alarm controller, bound to the top level
module tac_checker
  import tac_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // buzzer only sounds while armed
  a_drive_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[3] || out_tdata[2])
    else $error("buzzer sounding while disarmed");

  // low limit saves only come from set-low mode
  a_save_low_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[1:0] == MODE_SET_LOW && !out_tdata[14])
    else $error("low limit saved outside set-low mode");

  // high limit saves only come from set-high mode
  a_save_high_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> out_tdata[1:0] == MODE_SET_HIGH)
    else $error("high limit saved outside set-high mode");

endmodule

bind temperature_alarm_controller_core tac_checker u_tac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/sv/tb_temperature_alarm_controller_core.sv]
// self-checking testbench of the temperature alarm controller core
`timescale 1ns / 1ps

module tb_temperature_alarm_controller_core;
  import tac_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] temp;
  } stim_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] temperature
  logic [2:0]  in_tuser = '0;   // [2:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [1:0] mode, [2] buzzer_enable, [3] buzzer_drive,
                                // [4] pump_drive, [12:5] shown_value, [13] save_low,
                                // [14] save_high
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  temperature_alarm_controller_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predicted controller state and its configuration
  mode_t       cur_mode = MODE_NORMAL;
  logic [7:0]  lo_lim = DEFAULT_LOW;
  logic [7:0]  hi_lim = DEFAULT_HIGH;
  logic        armed = 1'b0;
  phase_t      beep_ph = PH_IDLE;
  logic [15:0] beep_cnt = '0;
  logic        pump_lvl = 1'b1;
  logic [7:0]  disp_val = '0;
  logic [15:0] cf_pause = RST_PAUSE_TICKS;
  logic [15:0] cf_on = RST_ON_TICKS;
  logic [7:0]  cf_ceiling = RST_LIMIT_CEILING;
  logic [7:0]  cf_margin = RST_REARM_MARGIN;

  stim_item_t stim_q[$];
  res_t       alarm_results_q[$];
  int         items_queued = 0;
  int         items_taken = 0;
  int         err_count = 0;
  int         send_idle_pct = 0;
  int         rdy_idle_pct = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         cycle_cnt = 0;

  task automatic drop_alarm();
    armed = 1'b0;
    beep_ph = PH_IDLE;
    beep_cnt = '0;
  endtask

  task automatic compute_alarm_outputs(input logic [2:0] op, input logic [15:0] temp,
                                       output res_t r);
    int t, hi10, lo10, re10;
    logic [8:0] h;
    logic sv_lo, sv_hi;
    t = int'($signed(temp));
    hi10 = int'(hi_lim) * 10;
    lo10 = int'(lo_lim) * 10;
    re10 = (int'(hi_lim) + int'(cf_margin)) * 10;
    sv_lo = 1'b0;
    sv_hi = 1'b0;
    case (op)
      OP_TICK: begin
        if (!armed) begin
          beep_ph = PH_IDLE;
          beep_cnt = '0;
        end else if (beep_ph == PH_PAUSE) begin
          if (beep_cnt <= 16'd1) begin
            beep_ph = PH_SOUND;
            beep_cnt = cf_on;
          end else begin
            beep_cnt = beep_cnt - 16'd1;
          end
        end else if (beep_ph == PH_SOUND) begin
          if (beep_cnt <= 16'd1) begin
            beep_ph = PH_IDLE;
            beep_cnt = '0;
          end else begin
            beep_cnt = beep_cnt - 16'd1;
          end
        end else begin
          beep_ph = PH_PAUSE;
          beep_cnt = cf_pause;
        end
      end
      OP_SAMPLE: begin
        if (cur_mode == MODE_NORMAL) begin
          if (t >= hi10) begin
            armed = 1'b1;
            cur_mode = MODE_ALARM;
          end
        end else if (cur_mode == MODE_ALARM) begin
          if (t <= lo10) begin
            drop_alarm();
            cur_mode = MODE_NORMAL;
          end
          if (t >= re10) armed = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (cur_mode == MODE_NORMAL || cur_mode == MODE_ALARM) begin
          cur_mode = MODE_SET_LOW;
          disp_val = lo_lim;
        end else if (cur_mode == MODE_SET_LOW) begin
          cur_mode = MODE_SET_HIGH;
          disp_val = hi_lim;
        end else begin
          cur_mode = MODE_NORMAL;
        end
      end
      OP_KEY1, OP_KEY2: begin
        if (cur_mode == MODE_NORMAL || cur_mode == MODE_ALARM) begin
          if (armed) drop_alarm();
          else pump_lvl = ~pump_lvl;
        end else if (cur_mode == MODE_SET_LOW) begin
          if (op == OP_KEY2) begin
            lo_lim = (lo_lim < 8'd255) ? lo_lim + 8'd1 : 8'd255;
            if (lo_lim == hi_lim) lo_lim = (hi_lim > 8'd0) ? hi_lim - 8'd1 : 8'd0;
          end else begin
            lo_lim = (lo_lim > 8'd0) ? lo_lim - 8'd1 : 8'd0;
            if (lo_lim == 8'd0) lo_lim = 8'd1;
          end
          disp_val = lo_lim;
          sv_lo = 1'b1;
        end else begin
          if (op == OP_KEY2) begin
            h = {1'b0, hi_lim} + 9'd1;
            hi_lim = (h > {1'b0, cf_ceiling}) ? cf_ceiling : h[7:0];
          end else begin
            hi_lim = (hi_lim > 8'd0) ? hi_lim - 8'd1 : 8'd0;
            if (hi_lim == lo_lim) hi_lim = (lo_lim < 8'd255) ? lo_lim + 8'd1 : 8'd255;
          end
          disp_val = hi_lim;
          sv_hi = 1'b1;
        end
      end
      default: ;
    endcase
    r.mode = cur_mode;
    r.buzzer_enable = armed;
    r.buzzer_drive = (beep_ph == PH_SOUND);
    r.pump_drive = pump_lvl;
    r.shown_value = disp_val;
    r.save_low = sv_lo;
    r.save_high = sv_hi;
  endtask

  // driver: offers queued items, predicts each accepted transaction
  always @(posedge clk) begin : drv
    res_t pred;
    stim_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        compute_alarm_outputs(in_tuser, in_tdata, pred);
        alarm_results_q.push_back(pred);
        items_taken <= items_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.op;
          in_tdata <= nxt.temp;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction and paces out_tready
  always @(posedge clk) begin : mon
    res_t want;
    res_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[14:0];
        if (alarm_results_q.size() == 0) begin
          $display("%0t: result with no expectation, got %h", $time, out_tdata);
          err_count++;
        end else begin
          want = alarm_results_q.pop_front();
          if (out_tdata !== {1'b0, want}) begin
            $display("%0t: mismatch exp mode=%0d en=%0b drv=%0b pump=%0b shown=%0d lo=%0b hi=%0b",
                     $time, want.mode, want.buzzer_enable, want.buzzer_drive, want.pump_drive,
                     want.shown_value, want.save_low, want.save_high);
            $display("%0t: mismatch got mode=%0d en=%0b drv=%0b pump=%0b shown=%0d lo=%0b hi=%0b",
                     $time, got.mode, got.buzzer_enable, got.buzzer_drive, got.pump_drive,
                     got.shown_value, got.save_low, got.save_high);
            err_count++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rdy_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input op_t op, input logic [15:0] temp);
    stim_item_t it;
    it.op = op;
    it.temp = temp;
    stim_q.push_back(it);
    items_queued++;
  endtask

  task automatic wait_taken();
    while (items_taken != items_queued) @(posedge clk);
  endtask

  task automatic settle();
    wait_taken();
    while (alarm_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_PAUSE_TICKS:   cf_pause = val[15:0];
      REG_ON_TICKS:      cf_on = val[15:0];
      REG_LIMIT_CEILING: cf_ceiling = val[7:0];
      default:           cf_margin = val[7:0];
    endcase
  endtask

  task automatic cfg_all(input int pause, input int on, input int ceil, input int margin);
    cfg_write(REG_PAUSE_TICKS, pause);
    cfg_write(REG_ON_TICKS, on);
    cfg_write(REG_LIMIT_CEILING, ceil);
    cfg_write(REG_REARM_MARGIN, margin);
  endtask

  // half of the temperatures cluster around the current thresholds, the rest are random
  function automatic logic [15:0] pick_temperature();
    int v;
    case ($urandom_range(5))
      0: v = int'(hi_lim) * 10 + int'($urandom_range(4)) - 2;
      1: v = int'(lo_lim) * 10 + int'($urandom_range(4)) - 2;
      2: v = (int'(hi_lim) + int'(cf_margin)) * 10 + int'($urandom_range(4)) - 2;
      3: v = $urandom_range(3000);
      default: v = $urandom();
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] rand_word();
    int v;
    v = $urandom();
    return v[15:0];
  endfunction

  task automatic key_burst();
    int len;
    int sel;
    bit same;
    op_t k;
    sel = $urandom_range(99);
    if (sel < 60) len = $urandom_range(1, 8);
    else if (sel < 96) len = $urandom_range(9, 40);
    else len = $urandom_range(200, 260);
    same = ($urandom_range(99) < 70);
    k = op_t'($urandom_range(1) ? OP_KEY2 : OP_KEY1);
    repeat (len) begin
      if (!same) k = op_t'($urandom_range(1) ? OP_KEY2 : OP_KEY1);
      push_item(k, rand_word());
    end
  endtask

  task automatic queue_episode();
    int kind;
    int len;
    kind = $urandom_range(9);
    if (kind >= 4) wait_taken();
    case (kind)
      0, 1, 2, 3: begin
        // beep cadence: optionally arm first, then a run of ticks with occasional samples
        if ($urandom_range(1))
          push_item(OP_SAMPLE, 16'(int'(hi_lim) * 10 + int'($urandom_range(20))));
        len = 2 * (int'(cf_pause) + int'(cf_on)) + 4;
        if (len > 40) len = 40;
        len = $urandom_range(1, len);
        repeat (len) begin
          if ($urandom_range(99) < 8) push_item(OP_SAMPLE, pick_temperature());
          else push_item(OP_TICK, rand_word());
        end
      end
      4, 5: begin
        repeat ($urandom_range(1, 6)) push_item(OP_SAMPLE, pick_temperature());
      end
      6: begin
        repeat ($urandom_range(1, 3))
          push_item(op_t'($urandom_range(1) ? OP_KEY2 : OP_KEY1), rand_word());
      end
      7, 8: begin
        // limit edit: reach set-low, step, then mostly set-high, step and back to normal
        if (cur_mode == MODE_NORMAL || cur_mode == MODE_ALARM) begin
          push_item(OP_RELEASE, rand_word());
        end else if (cur_mode == MODE_SET_HIGH) begin
          push_item(OP_RELEASE, rand_word());
          push_item(OP_RELEASE, rand_word());
        end
        key_burst();
        if ($urandom_range(99) < 85) begin
          push_item(OP_RELEASE, rand_word());
          key_burst();
          if ($urandom_range(99) < 80) push_item(OP_RELEASE, rand_word());
        end
      end
      default: begin
        repeat ($urandom_range(1, 6)) push_item(op_t'($urandom_range(4)), rand_word());
      end
    endcase
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_queued + count;
    while (items_queued < target) queue_episode();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // a few transactions under the reset configuration
    push_item(OP_TICK, 16'h0000);
    push_item(OP_SAMPLE, 16'h8000);
    push_item(OP_SAMPLE, 16'h7FFF);
    push_item(OP_KEY1, 16'hFFFF);
    push_item(OP_SAMPLE, 16'd200);
    settle();

    // directed: thresholds, cadence, silencing, pump, limit steps
    cfg_all(3, 2, 50, 5);
    push_item(OP_SAMPLE, 16'd299);
    push_item(OP_SAMPLE, 16'd300);
    repeat (6) push_item(OP_TICK, 16'h5A5A);
    push_item(OP_SAMPLE, 16'd200);      // disarm in alarm mode after the beep sequence
    push_item(OP_SAMPLE, 16'd350);
    push_item(OP_KEY2, 16'h0000);
    push_item(OP_SAMPLE, 16'd349);
    push_item(OP_SAMPLE, 16'd350);      // re-arm in alarm
    push_item(OP_KEY1, 16'h0000);
    push_item(OP_KEY1, 16'h0000);
    push_item(OP_KEY2, 16'h0000);
    push_item(OP_SAMPLE, 16'h8000);
    push_item(OP_RELEASE, 16'h0000);
    push_item(OP_KEY1, 16'h0000);
    push_item(OP_KEY2, 16'h0000);
    push_item(OP_SAMPLE, 16'h7FFF);     // ignored in set mode
    push_item(OP_RELEASE, 16'h0000);
    push_item(OP_KEY2, 16'h0000);
    push_item(OP_KEY1, 16'h0000);
    push_item(OP_RELEASE, 16'h0000);
    settle();

    send_idle_pct = 37;
    rdy_idle_pct = 88;
    cfg_all(1, 1, 255, 0);
    run_random(120);
    settle();

    send_idle_pct = 88;
    rdy_idle_pct = 37;
    cfg_all($urandom_range(2, 12), $urandom_range(1, 8), 2, 255);
    run_random(120);
    settle();

    send_idle_pct = 0;
    rdy_idle_pct = 0;
    cfg_all(65535, 65535, $urandom_range(40, 255), $urandom_range(20));
    push_item(OP_SAMPLE, 16'h7FFF);
    repeat (30) push_item(OP_TICK, rand_word());
    settle();

    cfg_write(REG_PAUSE_TICKS, $urandom_range(2, 20));
    cfg_write(REG_ON_TICKS, $urandom_range(1, 10));
    repeat (40) push_item(op_t'($urandom_range(1) ? OP_TICK : OP_SAMPLE), pick_temperature());
    hold_req++;                         // long output stall while input keeps coming
    run_random(110);
    settle();
    repeat (8) @(posedge clk);

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[temperature_alarm_controller_core.f]
sv/tac_pkg.sv
sv/tac_in_stage.sv
sv/tac_ctrl.sv
sv/tac_out_stage.sv
sv/temperature_alarm_controller_core.sv
sv/tac_checker.sv
tb/sv/tb_temperature_alarm_controller_core.sv
